// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL module lpi_ctrl.
// Each one samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/lpi_pkg.sv =====
package lpi_pkg;

	localparam int POLY_SLOTS = 8;
	localparam int POLY_COUNT_DEF = 8;
	localparam int ERROR_THRESHOLD_DEF = 0;

	localparam int WORD_W = 64;
	localparam int SEED_W = 17;
	localparam int IDX_W = 3;
	localparam int SKIP_W = 4;
	localparam int CNT_W = 6;
	localparam int STEP_W = 6;
	localparam int THR_W = 5;
	localparam int TRY_W = 3;
	localparam int TRY_COUNT = 5;

	localparam logic [TRY_W-1:0] TRY_LAST = TRY_W'(TRY_COUNT - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(39);
	localparam logic [THR_W-1:0] THR_FLOOR = THR_W'(2);

	// Seed of the skip-8 run sits in bits 55:39, that of the skip-9 run in 54:38.
	localparam int SEED8_LSB = 39;
	localparam int SEED9_LSB = 38;
	// After k left shifts of the word, these bits hold the chip compared at step k.
	localparam int RX8_BIT = 38;
	localparam int RX9_BIT = 37;

	localparam logic [SKIP_W-1:0] SKIP_EVEN = SKIP_W'(8);
	localparam logic [SKIP_W-1:0] SKIP_ODD = SKIP_W'(9);

	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	// Compared bits of each try, in try order. Odd tries use the skip-9 run.
	localparam logic [STEP_W-1:0] TRY_LEN [TRY_COUNT] = '{
		STEP_W'(39), STEP_W'(38), STEP_W'(29), STEP_W'(28), STEP_W'(19)
	};

	typedef logic [TRY_W-1:0] try_t;

	typedef struct packed {
		logic load;
		logic step;
		logic snap;
		try_t try_sel;
	} lpi_cmd_t;

	typedef struct packed {
		logic word_zero;
		logic [CNT_W-1:0] best_cnt;
		logic [IDX_W-1:0] best_idx;
	} lpi_sts_t;

endpackage

// ===== src/lpi_dp.sv =====
module lpi_dp #(
	parameter int POLY_COUNT = lpi_pkg::POLY_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lpi_pkg::IDX_W-1:0] cfg_index,
	input logic [lpi_pkg::SEED_W-1:0] cfg_data,
	input logic [lpi_pkg::WORD_W-1:0] chip_word,
	input lpi_pkg::lpi_cmd_t cmd,
	output lpi_pkg::lpi_sts_t sts
);

	logic [lpi_pkg::SEED_W-1:0] taps_q [POLY_COUNT];
	logic [lpi_pkg::WORD_W-1:0] sh_q;
	logic [lpi_pkg::SEED_W-1:0] lfsr8_q [POLY_COUNT];
	logic [lpi_pkg::SEED_W-1:0] lfsr9_q [POLY_COUNT];
	logic [lpi_pkg::CNT_W-1:0] cnt8_q [POLY_COUNT];
	logic [lpi_pkg::CNT_W-1:0] cnt9_q [POLY_COUNT];
	logic [lpi_pkg::CNT_W-1:0] snap_q [lpi_pkg::TRY_COUNT][POLY_COUNT];
	logic fb8 [POLY_COUNT];
	logic fb9 [POLY_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POLY_COUNT; i++) begin
				taps_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < POLY_COUNT; i++) begin
				if (cfg_we && cfg_index == lpi_pkg::IDX_W'(i)) begin
					taps_q[i] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < POLY_COUNT; i++) begin
			fb8[i] = ^(lfsr8_q[i] & taps_q[i]);
			fb9[i] = ^(lfsr9_q[i] & taps_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q <= chip_word;
			for (int i = 0; i < POLY_COUNT; i++) begin
				lfsr8_q[i] <= chip_word[lpi_pkg::SEED8_LSB +: lpi_pkg::SEED_W];
				lfsr9_q[i] <= chip_word[lpi_pkg::SEED9_LSB +: lpi_pkg::SEED_W];
				cnt8_q[i] <= '0;
				cnt9_q[i] <= '0;
			end
		end else if (cmd.step) begin
			sh_q <= {sh_q[lpi_pkg::WORD_W-2:0], 1'b0};
			for (int i = 0; i < POLY_COUNT; i++) begin
				lfsr8_q[i] <= {lfsr8_q[i][lpi_pkg::SEED_W-2:0], fb8[i]};
				lfsr9_q[i] <= {lfsr9_q[i][lpi_pkg::SEED_W-2:0], fb9[i]};
				if (fb8[i] != sh_q[lpi_pkg::RX8_BIT]) begin
					cnt8_q[i] <= cnt8_q[i] + lpi_pkg::CNT_W'(1);
				end
				if (fb9[i] != sh_q[lpi_pkg::RX9_BIT]) begin
					cnt9_q[i] <= cnt9_q[i] + lpi_pkg::CNT_W'(1);
				end
			end
		end
		if (cmd.snap) begin
			for (int i = 0; i < POLY_COUNT; i++) begin
				snap_q[cmd.try_sel][i] <= cmd.try_sel[0] ? cnt9_q[i] : cnt8_q[i];
			end
		end
	end

	always_comb begin
		sts.word_zero = (chip_word == '0);
		sts.best_cnt = snap_q[cmd.try_sel][0];
		sts.best_idx = '0;
		for (int i = 1; i < POLY_COUNT; i++) begin
			if (snap_q[cmd.try_sel][i] < sts.best_cnt) begin
				sts.best_cnt = snap_q[cmd.try_sel][i];
				sts.best_idx = lpi_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// ===== src/lpi_ctrl.sv =====
`include "assert_macros.svh"

module lpi_ctrl #(
	parameter int ERROR_THRESHOLD = lpi_pkg::ERROR_THRESHOLD_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	output logic status,
	output logic [lpi_pkg::IDX_W-1:0] poly_index,
	output logic [lpi_pkg::SKIP_W-1:0] skip_bits,
	output lpi_pkg::lpi_cmd_t cmd,
	input lpi_pkg::lpi_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic [lpi_pkg::STEP_W-1:0] step_q;
	lpi_pkg::try_t try_q;
	logic [lpi_pkg::THR_W-1:0] thr_q;
	logic busy_q;
	logic done_q;
	logic status_q;
	logic [lpi_pkg::IDX_W-1:0] poly_index_q;
	logic [lpi_pkg::SKIP_W-1:0] skip_bits_q;
	logic snap_hit;
	lpi_pkg::try_t snap_try;
	logic pass;

	always_comb begin
		snap_hit = 1'b0;
		snap_try = '0;
		for (int t = 0; t < lpi_pkg::TRY_COUNT; t++) begin
			if (step_q == lpi_pkg::TRY_LEN[t]) begin
				snap_hit = 1'b1;
				snap_try = lpi_pkg::TRY_W'(t);
			end
		end
	end

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.step = (state_q == ST_RUN) && (step_q != lpi_pkg::LAST_STEP);
		cmd.snap = (state_q == ST_RUN) && snap_hit;
		cmd.try_sel = (state_q == ST_RUN) ? snap_try : try_q;
	end

	assign pass = (sts.best_cnt <= lpi_pkg::CNT_W'(thr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			try_q <= '0;
			thr_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= lpi_pkg::STATUS_ERROR;
			poly_index_q <= '0;
			skip_bits_q <= lpi_pkg::SKIP_EVEN;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						thr_q <= lpi_pkg::THR_W'(ERROR_THRESHOLD);
						step_q <= '0;
						try_q <= '0;
						if (sts.word_zero) begin
							done_q <= 1'b1;
							status_q <= lpi_pkg::STATUS_ERROR;
							poly_index_q <= '0;
							skip_bits_q <= lpi_pkg::SKIP_EVEN;
						end else begin
							busy_q <= 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (step_q == lpi_pkg::LAST_STEP) begin
						state_q <= ST_EVAL;
					end else begin
						step_q <= step_q + lpi_pkg::STEP_W'(1);
					end
				end
				ST_EVAL: begin
					if (pass) begin
						done_q <= 1'b1;
						status_q <= lpi_pkg::STATUS_FOUND;
						poly_index_q <= sts.best_idx;
						skip_bits_q <= try_q[0] ? lpi_pkg::SKIP_ODD : lpi_pkg::SKIP_EVEN;
						busy_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (try_q == lpi_pkg::TRY_LAST) begin
						done_q <= 1'b1;
						status_q <= lpi_pkg::STATUS_ERROR;
						poly_index_q <= '0;
						skip_bits_q <= lpi_pkg::SKIP_EVEN;
						busy_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						if (try_q[0] && thr_q > lpi_pkg::THR_FLOOR) begin
							thr_q <= thr_q - lpi_pkg::THR_W'(1);
						end
						try_q <= try_q + lpi_pkg::TRY_W'(1);
					end
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign status = status_q;
	assign poly_index = poly_index_q;
	assign skip_bits = skip_bits_q;

	`ASSERT_SAME(a_done_not_busy, done_q, !busy_q)
	`ASSERT_NEXT(a_start_runs, start && !busy_q && !sts.word_zero,
		busy_q && (state_q == ST_RUN))
	`ASSERT_SAME(a_error_fields, done_q && (status_q == lpi_pkg::STATUS_ERROR),
		(poly_index_q == '0) && (skip_bits_q == lpi_pkg::SKIP_EVEN))
	`ASSERT_SAME(a_skip_range, done_q,
		(skip_bits_q == lpi_pkg::SKIP_EVEN) || (skip_bits_q == lpi_pkg::SKIP_ODD))

endmodule

// ===== src/lfsr_polynomial_identifier.sv =====
// Identifies which of the configured 17-bit LFSR polynomials produced a 64-bit chip word,
// earliest chip in bit 63. An item is accepted at a clock edge with start high and busy low.
// A zero word gives its error result on done in the very next cycle; any other word runs
// through two phases after acceptance: all candidates run two LFSR lanes each (seed
// after 8 and after 9 skipped chips) for 39 steps, one step per cycle, then one try at a
// time (up to five) picks the best candidate. Result fields are valid only while done is
// high, for exactly one cycle, and the receiver cannot stall them. busy falls as done rises,
// so the next item may start in the done cycle. Write the poly registers only while idle.
module lfsr_polynomial_identifier #(
	parameter int POLY_COUNT = lpi_pkg::POLY_COUNT_DEF,
	parameter int ERROR_THRESHOLD = lpi_pkg::ERROR_THRESHOLD_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lpi_pkg::IDX_W-1:0] cfg_index,
	input logic [lpi_pkg::SEED_W-1:0] cfg_data,
	input logic start,
	output logic busy,
	input logic [lpi_pkg::WORD_W-1:0] chip_word,
	output logic done,
	output logic status,
	output logic [lpi_pkg::IDX_W-1:0] poly_index,
	output logic [lpi_pkg::SKIP_W-1:0] skip_bits
);

	lpi_pkg::lpi_cmd_t cmd;
	lpi_pkg::lpi_sts_t sts;

	lpi_dp #(
		.POLY_COUNT(POLY_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.chip_word(chip_word),
		.cmd(cmd),
		.sts(sts)
	);

	lpi_ctrl #(
		.ERROR_THRESHOLD(ERROR_THRESHOLD)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.status(status),
		.poly_index(poly_index),
		.skip_bits(skip_bits),
		.cmd(cmd),
		.sts(sts)
	);

endmodule
